// ===== hw/rtl/mm_pkg.sv =====
// Package for the matrix multiply core: sizes, mode and register codes,
// request, response and pipeline tag word types.
// No dependencies.
package mm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int VALUE_BITS = 16;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int IDX_BITS   = $clog2(MAX_DIM);
   localparam int DIM_BITS   = 4;
   localparam int PROD_BITS  = 2 * VALUE_BITS;
   localparam int SUM_BITS   = 36;
   localparam int ELEM_BITS  = 16;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   localparam logic [1:0] MODE_LOAD_A  = 2'd0;
   localparam logic [1:0] MODE_LOAD_B  = 2'd1;
   localparam logic [1:0] MODE_COMPUTE = 2'd2;

   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_LEN = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;

   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(MAX_DIM);

   typedef struct packed {
      logic [1:0]                  mode;
      logic [5:0]                  element_index;
      logic signed [ELEM_BITS-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] product_sum;
      logic [2:0]                 out_row;
      logic [2:0]                 out_col;
      logic                       last_result;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                first;
      logic                dot_end;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
      logic                final_elem;
   } tag_type;

endpackage

// ===== hw/rtl/matrix_multiply_core.sv =====
// Fixed-point matrix multiply core, C = A * B, on one shared multiply-accumulate unit.
// Depends on mm_pkg.
//
// Usage:
//   Input: a word on req_word is taken at a clock edge with start high and busy low.
//   Mode load A / load B writes element_value into the A or B store at element_index
//   (row-major, using the dimensions in force at compute time).
//   Mode compute emits every element of C in row-major order on rsp_word, each for
//   one cycle under rsp_strobe, with out_row, out_col and last_result on the final one.
//   Throughput: one multiply-accumulate per cycle, one result per dot product of
//   length k (k = inner length); busy stays high while the sequencer runs and
//   products remain in the read or multiply stage. Each product passes through the
//   registered read, multiply and add stages of the single MAC.
//   Configuration: APB port, rows_a at 0x0, inner_len at 0x4, cols_b at 0x8, which are
//   to be written only while idle; the block does not enforce this. A dimension of 0
//   acts as 1, above 8 as 8. Reset: synchronous; dimensions return to 8, the
//   sequencer goes idle, stores keep undefined contents until written.
//   The receiver cannot stall: each result is valid for exactly one cycle.
module matrix_multiply_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  mm_pkg::req_type            req_word,
   output logic                       rsp_strobe,
   output mm_pkg::rsp_type            rsp_word,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mm_pkg::CSR_AW-1:0]  paddr,
   input  logic [mm_pkg::CSR_DW-1:0]  pwdata,
   output logic [mm_pkg::CSR_DW-1:0]  prdata,
   output logic                       pready
);
   import mm_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // configuration
   logic [DIM_BITS-1:0] rows_a_ff, inner_len_ff, cols_b_ff;
   logic [DIM_BITS-1:0] m_eff, k_eff, n_eff;
   logic [IDX_BITS-1:0] m_last, k_last, n_last;
   logic [1:0]          csr_index;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_len_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROWS_A:    rows_a_ff    <= pwdata[DIM_BITS-1:0];
            REG_INNER_LEN: inner_len_ff <= pwdata[DIM_BITS-1:0];
            REG_COLS_B:    cols_b_ff    <= pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROWS_A:    prdata = CSR_DW'(rows_a_ff);
         REG_INNER_LEN: prdata = CSR_DW'(inner_len_ff);
         REG_COLS_B:    prdata = CSR_DW'(cols_b_ff);
         default:       prdata = '0;
      endcase
   end

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] r);
      logic [DIM_BITS-1:0] v;
      if (r == '0) begin
         v = DIM_BITS'(1);
      end else if (r > DIM_BITS'(MAX_DIM)) begin
         v = DIM_BITS'(MAX_DIM);
      end else begin
         v = r;
      end
      return v;
   endfunction

   always_comb begin
      m_eff  = clamp_dim(rows_a_ff);
      k_eff  = clamp_dim(inner_len_ff);
      n_eff  = clamp_dim(cols_b_ff);
      m_last = IDX_BITS'(m_eff - DIM_BITS'(1));
      k_last = IDX_BITS'(k_eff - DIM_BITS'(1));
      n_last = IDX_BITS'(n_eff - DIM_BITS'(1));
   end

   // input handshake
   logic accept;
   logic a_we, b_we, go;

   assign accept = start & ~busy;
   assign a_we   = accept & (req_word.mode == MODE_LOAD_A);
   assign b_we   = accept & (req_word.mode == MODE_LOAD_B);
   assign go     = accept & (req_word.mode == MODE_COMPUTE);

   // sequencer
   logic                 state_ff, state_in;
   logic [IDX_BITS-1:0]  i_ff, i_in, j_ff, j_in, p_ff, p_in;
   logic [ADDR_BITS-1:0] a_base_ff, a_base_in, b_addr_ff, b_addr_in;
   logic [ADDR_BITS-1:0] a_rd_addr;
   tag_type              issue_tag;

   assign a_rd_addr = a_base_ff + ADDR_BITS'(p_ff);

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      p_in      = p_ff;
      a_base_in = a_base_ff;
      b_addr_in = b_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in  = ST_RUN;
               i_in      = '0;
               j_in      = '0;
               p_in      = '0;
               a_base_in = '0;
               b_addr_in = '0;
            end
         end
         ST_RUN: begin
            if (p_ff != k_last) begin
               p_in      = p_ff + IDX_BITS'(1);
               b_addr_in = b_addr_ff + ADDR_BITS'(n_eff);
            end else begin
               p_in = '0;
               if (j_ff != n_last) begin
                  j_in      = j_ff + IDX_BITS'(1);
                  b_addr_in = ADDR_BITS'(j_ff) + ADDR_BITS'(1);
               end else begin
                  j_in      = '0;
                  b_addr_in = '0;
                  if (i_ff != m_last) begin
                     i_in      = i_ff + IDX_BITS'(1);
                     a_base_in = a_base_ff + ADDR_BITS'(k_eff);
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      issue_tag.valid      = (state_ff == ST_RUN);
      issue_tag.first      = (p_ff == '0);
      issue_tag.dot_end    = (p_ff == k_last);
      issue_tag.row        = i_ff;
      issue_tag.col        = j_ff;
      issue_tag.final_elem = (i_ff == m_last) && (j_ff == n_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      p_ff      <= p_in;
      a_base_ff <= a_base_in;
      b_addr_ff <= b_addr_in;
   end

   // element stores
   logic signed [VALUE_BITS-1:0] a_mem [DEPTH];
   logic signed [VALUE_BITS-1:0] b_mem [DEPTH];
   logic signed [VALUE_BITS-1:0] a_q_ff, b_q_ff;

   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[req_word.element_index] <= VALUE_BITS'(req_word.element_value);
      end
      a_q_ff <= a_mem[a_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[req_word.element_index] <= VALUE_BITS'(req_word.element_value);
      end
      b_q_ff <= b_mem[b_addr_ff];
   end

   // multiply-accumulate pipeline
   tag_type                      rd_tag_ff, mul_tag_ff;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [SUM_BITS-1:0]   acc_ff, acc_in;
   logic                         rsp_strobe_ff;
   rsp_type                      rsp_word_ff;

   always_comb begin
      acc_in = (mul_tag_ff.first ? SUM_BITS'(0) : acc_ff)
             + {{(SUM_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff.valid  <= 1'b0;
         mul_tag_ff.valid <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         rd_tag_ff.valid  <= issue_tag.valid;
         mul_tag_ff.valid <= rd_tag_ff.valid;
         rsp_strobe_ff    <= mul_tag_ff.valid & mul_tag_ff.dot_end;
      end
      rd_tag_ff.first      <= issue_tag.first;
      rd_tag_ff.dot_end    <= issue_tag.dot_end;
      rd_tag_ff.row        <= issue_tag.row;
      rd_tag_ff.col        <= issue_tag.col;
      rd_tag_ff.final_elem <= issue_tag.final_elem;
      mul_tag_ff.first      <= rd_tag_ff.first;
      mul_tag_ff.dot_end    <= rd_tag_ff.dot_end;
      mul_tag_ff.row        <= rd_tag_ff.row;
      mul_tag_ff.col        <= rd_tag_ff.col;
      mul_tag_ff.final_elem <= rd_tag_ff.final_elem;
      prod_ff <= PROD_BITS'(a_q_ff) * PROD_BITS'(b_q_ff);
      if (mul_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
      rsp_word_ff.product_sum <= acc_in;
      rsp_word_ff.out_row     <= 3'(mul_tag_ff.row);
      rsp_word_ff.out_col     <= 3'(mul_tag_ff.col);
      rsp_word_ff.last_result <= mul_tag_ff.final_elem;
   end

   assign busy       = (state_ff == ST_RUN) | rd_tag_ff.valid | mul_tag_ff.valid;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

`ifndef SYNTHESIS
   a_go_runs: assert property (@(posedge clock) disable iff (reset)
      go |=> (state_ff == ST_RUN))
      else $error("compute word accepted but sequencer not running");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(busy))
      else $error("result strobe without preceding busy");

   a_last_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_word_ff.last_result) |->
         (state_ff == ST_IDLE && !rd_tag_ff.valid && !mul_tag_ff.valid))
      else $error("final result while work still in flight");
`endif

endmodule
